/* sv/rmp_pkg.sv */
// ----------------------------------------------------------------------------
// rmp_pkg
// Shared types and constants of the region mosaic pixelate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rmp_pkg;

    localparam int PIXEL_W  = 32;
    localparam int POS_W    = 10;
    localparam int SIZE_W   = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 11;
    localparam int DIV_W    = 11;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_W    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_H    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 3'd5;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_in;
        logic               frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_out;
        logic               in_mosaic;
    } t_pix_out;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } t_div_rsp;

endpackage

`default_nettype wire

/* sv/rmp_pix_in_if.sv */
// ----------------------------------------------------------------------------
// rmp_pix_in_if
// Valid/ready channel carrying input pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmp_pix_in_if import rmp_pkg::*; ();
    logic    valid;
    logic    ready;
    t_pix_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/rmp_pix_out_if.sv */
// ----------------------------------------------------------------------------
// rmp_pix_out_if
// Valid/ready channel carrying output pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmp_pix_out_if import rmp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_pix_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/region_mosaic_pixelate_unit.sv */
// ----------------------------------------------------------------------------
// region_mosaic_pixelate_unit
// Mosaic filter over a rectangle of a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in steady state, while the output accepts results;
// each result passes a stage register and then an output register, so one
// more pixel is taken while a result waits. Block colors live in a 1024 x 32
// single-port synchronous memory: the first pixel of a block writes its
// entry, later pixels of the block read it back. Block sizes and the block
// position of the current pixel come from a shared one-bit-per-cycle
// divider run four times in series after reset and after each write of
// region_x, region_y, region_w, region_h or block_count; input ready stays
// low during that setup. Between pixels the block position advances by
// counting, with no division.
`default_nettype none

module region_mosaic_pixelate_unit import rmp_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    rmp_pix_in_if.sink                i_pix,
    rmp_pix_out_if.source             o_pix,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int MEM_DEPTH = 1 << POS_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SIZE_W = 5'b00010,
        ST_SIZE_H = 5'b00100,
        ST_TRK_C  = 5'b01000,
        ST_TRK_R  = 5'b10000
    } t_seq_state;

    // configuration
    logic [SIZE_W-1:0] r_img_w;
    logic [POS_W-1:0]  r_reg_x;
    logic [POS_W-1:0]  r_reg_y;
    logic [SIZE_W-1:0] r_reg_w;
    logic [SIZE_W-1:0] r_reg_h;
    logic [SIZE_W-1:0] r_count;

    // block sizes and position of the next pixel
    logic [SIZE_W-1:0] r_bw, r_bh;
    logic [POS_W-1:0]  r_col, r_row;
    logic [POS_W-1:0]  r_k, r_ph, r_rph;
    logic [SIZE_W-1:0] r_cs, r_rs;

    // setup sequencer
    t_seq_state        r_state, n_state;
    logic              r_started, n_started;
    logic              w_restart;
    logic              w_div_fin;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;
    logic [POS_W-1:0]  w_dc, w_dr;

    // pixel path
    logic              w_accept;
    logic              w_adv_a;
    logic [POS_W-1:0]  w_col, w_row, w_k, w_ph, w_rph;
    logic [SIZE_W-1:0] w_cs, w_rs;
    logic              w_hit, w_cap;
    logic              w_wrap;
    logic [POS_W-1:0]  n_col, n_row, n_k, n_ph, n_rph;
    logic [SIZE_W-1:0] n_cs, n_rs;

    logic [PIXEL_W-1:0] r_mem [MEM_DEPTH];
    logic [PIXEL_W-1:0] r_rdata;
    logic               r_a_valid;
    logic [PIXEL_W-1:0] r_a_pix;
    logic               r_a_hit;
    logic               r_a_cap;
    logic               r_b_valid;
    logic [PIXEL_W-1:0] r_b_pix;
    logic               r_b_hit;

    rmp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ------------------------------------------------------------------
    // configuration and setup sequencer
    // ------------------------------------------------------------------
    always_comb begin
        w_restart = 1'b0;
        if (i_cfg_we) begin
            w_restart = i_cfg_idx inside {CFG_REGION_X, CFG_REGION_Y, CFG_REGION_W,
                                          CFG_REGION_H, CFG_BLOCK_COUNT};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= SIZE_W'(600);
            r_reg_x <= '0;
            r_reg_y <= '0;
            r_reg_w <= '0;
            r_reg_h <= '0;
            r_count <= SIZE_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH: r_img_w <= i_cfg_data;
                CFG_REGION_X:    r_reg_x <= i_cfg_data[POS_W-1:0];
                CFG_REGION_Y:    r_reg_y <= i_cfg_data[POS_W-1:0];
                CFG_REGION_W:    r_reg_w <= i_cfg_data;
                CFG_REGION_H:    r_reg_h <= i_cfg_data;
                CFG_BLOCK_COUNT: r_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_dc      = r_col - r_reg_x;
    assign w_dr      = r_row - r_reg_y;
    assign w_div_fin = r_started && w_div_rsp.done && !w_restart;

    always_comb begin
        n_state   = r_state;
        n_started = r_started;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_reg_w;
        w_div_req.divisor  = r_count;
        case (r_state)
            ST_SIZE_H: begin
                w_div_req.dividend = r_reg_h;
            end
            ST_TRK_C: begin
                w_div_req.dividend = {1'b0, w_dc};
                w_div_req.divisor  = r_bw;
            end
            ST_TRK_R: begin
                w_div_req.dividend = {1'b0, w_dr};
                w_div_req.divisor  = r_bh;
            end
            default: ;
        endcase
        if (w_restart) begin
            n_state   = ST_SIZE_W;
            n_started = 1'b0;
        end else if (r_state != ST_IDLE) begin
            if (!r_started) begin
                w_div_req.start = 1'b1;
                n_started       = 1'b1;
            end else if (w_div_rsp.done) begin
                n_started = 1'b0;
                case (r_state)
                    ST_SIZE_W: n_state = ST_SIZE_H;
                    ST_SIZE_H: n_state = ST_TRK_C;
                    ST_TRK_C:  n_state = ST_TRK_R;
                    default:   n_state = ST_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_SIZE_W;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
        end
    end

    // ------------------------------------------------------------------
    // position tracking
    // ------------------------------------------------------------------
    always_comb begin
        if (i_pix.data.frame_start) begin
            w_col = '0;
            w_row = '0;
            w_k   = '0;
            w_ph  = '0;
            w_rph = '0;
            w_cs  = '0;
            w_rs  = '0;
        end else begin
            w_col = r_col;
            w_row = r_row;
            w_k   = r_k;
            w_ph  = r_ph;
            w_rph = r_rph;
            w_cs  = r_cs;
            w_rs  = r_rs;
        end

        w_hit = (r_bw != '0) && (r_bh != '0) && (w_col >= r_reg_x) && (w_row >= r_reg_y)
                && (({1'b0, w_cs} + 12'd1) < {1'b0, r_reg_w})
                && (({1'b0, w_rs} + 12'd1) < {1'b0, r_reg_h});
        w_cap = w_hit && (w_ph == '0) && (w_rph == '0);

        w_wrap = (w_col == '1) ||
                 ((r_img_w != '0) && (({1'b0, w_col} + SIZE_W'(1)) >= r_img_w));

        n_row = w_row;
        n_rph = w_rph;
        n_rs  = w_rs;
        n_k   = w_k;
        n_ph  = w_ph;
        n_cs  = w_cs;
        if (w_wrap) begin
            n_col = '0;
            n_k   = '0;
            n_ph  = '0;
            n_cs  = '0;
            n_row = w_row + 1'b1;
            if (n_row == r_reg_y) begin
                n_rph = '0;
                n_rs  = '0;
            end else if (({1'b0, w_rph} + SIZE_W'(1)) == r_bh) begin
                n_rph = '0;
                n_rs  = w_rs + r_bh;
            end else begin
                n_rph = w_rph + 1'b1;
            end
        end else begin
            n_col = w_col + 1'b1;
            if (n_col == r_reg_x) begin
                n_k  = '0;
                n_ph = '0;
                n_cs = '0;
            end else if (({1'b0, w_ph} + SIZE_W'(1)) == r_bw) begin
                n_ph = '0;
                n_k  = w_k + 1'b1;
                n_cs = w_cs + r_bw;
            end else begin
                n_ph = w_ph + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw  <= '0;
            r_bh  <= '0;
            r_col <= '0;
            r_row <= '0;
            r_k   <= '0;
            r_ph  <= '0;
            r_rph <= '0;
            r_cs  <= '0;
            r_rs  <= '0;
        end else if (w_div_fin) begin
            case (r_state)
                ST_SIZE_W: r_bw <= (r_count == '0) ? '0 : w_div_rsp.quotient;
                ST_SIZE_H: r_bh <= (r_count == '0) ? '0 : w_div_rsp.quotient;
                ST_TRK_C: begin
                    r_k  <= w_div_rsp.quotient[POS_W-1:0];
                    r_ph <= w_div_rsp.remainder[POS_W-1:0];
                    r_cs <= {1'b0, w_dc} - w_div_rsp.remainder;
                end
                ST_TRK_R: begin
                    r_rph <= w_div_rsp.remainder[POS_W-1:0];
                    r_rs  <= {1'b0, w_dr} - w_div_rsp.remainder;
                end
                default: ;
            endcase
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
            r_k   <= n_k;
            r_ph  <= n_ph;
            r_rph <= n_rph;
            r_cs  <= n_cs;
            r_rs  <= n_rs;
        end
    end

    // ------------------------------------------------------------------
    // color store and output pipeline
    // ------------------------------------------------------------------
    assign w_adv_a     = r_a_valid && (!r_b_valid || o_pix.ready);
    assign i_pix.ready = (r_state == ST_IDLE) && (!r_a_valid || w_adv_a);
    assign w_accept    = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (w_accept && w_cap) begin
            r_mem[w_k] <= i_pix.data.pixel_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rdata <= r_mem[w_k];
            r_a_pix <= i_pix.data.pixel_in;
            r_a_hit <= w_hit;
            r_a_cap <= w_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_a) begin
            r_b_pix <= (r_a_hit && !r_a_cap) ? r_rdata : r_a_pix;
            r_b_hit <= r_a_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_a_valid <= 1'b1;
            end else if (w_adv_a) begin
                r_a_valid <= 1'b0;
            end
            if (w_adv_a) begin
                r_b_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    assign o_pix.valid          = r_b_valid;
    assign o_pix.data.pixel_out = r_b_pix;
    assign o_pix.data.in_mosaic = r_b_hit;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.ready |-> r_state == ST_IDLE)
        else $error("input ready during block setup");

    a_cfg_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_restart |=> !i_pix.ready)
        else $error("input not held off after region write");

    a_cap_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_cap) |-> r_a_hit)
        else $error("color capture outside a block");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> r_state != ST_IDLE)
        else $error("divider finished with sequencer idle");

endmodule

`default_nettype wire

/* sv/rmp_div.sv */
// ----------------------------------------------------------------------------
// rmp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rmp_div import rmp_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     r_div;

    logic [DIV_W:0]       w_shift;
    logic [DIV_W:0]       w_diff;
    logic                 w_fit;

    always_comb begin
        w_shift = {r_rem, r_quo[DIV_W-1]};
        w_diff  = w_shift - {1'b0, r_div};
        w_fit   = w_shift >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_CNT_W'(DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_fit};
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

/* tb/sv/region_mosaic_pixelate_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_mosaic_pixelate_unit_tb
// Self-checking bench for the region mosaic pixelate unit. Pixels stream in
// raster frames under many rectangle and block settings, including the
// extremes. A scoreboard model tracks position, block sizes and captured
// block colors and checks every output transaction in order. Both sides of
// the stream idle and stall at random.
// ----------------------------------------------------------------------------
module region_mosaic_pixelate_unit_tb import rmp_pkg::*; ();

    localparam int unsigned STORE_DEPTH   = 1024;
    localparam int unsigned MAX_COLS      = 1024;
    localparam int unsigned MAX_ROWS      = 1024;
    localparam int unsigned RANDOM_PIXELS = 1050;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 8;

    typedef struct {
        int unsigned image_width;
        int unsigned region_x;
        int unsigned region_y;
        int unsigned region_w;
        int unsigned region_h;
        int unsigned block_count;
    } mosaic_setting_t;

    typedef enum int unsigned {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    rmp_pix_in_if  pix_in_ch ();
    rmp_pix_out_if pix_out_ch ();

    region_mosaic_pixelate_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_in_ch),
        .o_pix      (pix_out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // scoreboard model state
    int unsigned        cfg_image_width, cfg_region_x, cfg_region_y;
    int unsigned        cfg_region_w, cfg_region_h, cfg_block_count;
    int unsigned        blk_w, blk_h;
    int unsigned        col_pos, row_pos;
    logic [PIXEL_W-1:0] block_colors [STORE_DEPTH];
    t_pix_out           expected_pixels [$];

    int unsigned fail_count       = 0;
    int unsigned pixels_sent      = 0;
    int unsigned pixels_checked   = 0;
    int unsigned mosaic_hits      = 0;
    int unsigned settings_applied = 0;
    int unsigned random_pixels    = 0;
    int unsigned burst_left       = 0;
    int unsigned cycle_count      = 0;

    function automatic void resize_blocks();
        if (cfg_block_count == 0) begin
            blk_w = 0;
            blk_h = 0;
        end else begin
            blk_w = (cfg_region_w / cfg_block_count) % 2048;
            blk_h = (cfg_region_h / cfg_block_count) % 2048;
        end
    endfunction

    function automatic void reset_mosaic_model();
        cfg_image_width = 600;
        cfg_region_x    = 0;
        cfg_region_y    = 0;
        cfg_region_w    = 0;
        cfg_region_h    = 0;
        cfg_block_count = 1;
        col_pos         = 0;
        row_pos         = 0;
        foreach (block_colors[i]) block_colors[i] = '0;
        resize_blocks();
    endfunction

    function automatic void model_write(input logic [CFG_IDX_W-1:0] idx,
                                        input int unsigned value);
        case (idx)
            CFG_IMAGE_WIDTH: cfg_image_width = value % 2048;
            CFG_REGION_X:    cfg_region_x    = value % 1024;
            CFG_REGION_Y:    cfg_region_y    = value % 1024;
            CFG_REGION_W:    cfg_region_w    = value % 2048;
            CFG_REGION_H:    cfg_region_h    = value % 2048;
            CFG_BLOCK_COUNT: cfg_block_count = value % 2048;
            default: ;
        endcase
        resize_blocks();
    endfunction

    function automatic t_pix_out predict_mosaic_pixel(input logic [PIXEL_W-1:0] pix,
                                                      input logic fs);
        t_pix_out    res;
        int unsigned dc, dr, col_start, row_start, slot, next_col;
        res.pixel_out = pix;
        res.in_mosaic = 1'b0;
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (blk_w != 0 && blk_h != 0 && col_pos >= cfg_region_x && row_pos >= cfg_region_y) begin
            dc        = col_pos - cfg_region_x;
            dr        = row_pos - cfg_region_y;
            col_start = (dc / blk_w) * blk_w;
            row_start = (dr / blk_h) * blk_h;
            if (col_start + 1 < cfg_region_w && row_start + 1 < cfg_region_h) begin
                slot = (dc / blk_w) % STORE_DEPTH;
                if (dc == col_start && dr == row_start) block_colors[slot] = pix;
                res.pixel_out = block_colors[slot];
                res.in_mosaic = 1'b1;
            end
        end
        next_col = col_pos + 1;
        if (next_col >= MAX_COLS || (cfg_image_width != 0 && next_col >= cfg_image_width)) begin
            col_pos = 0;
            row_pos = (row_pos + 1) % MAX_ROWS;
        end else begin
            col_pos = next_col;
        end
        return res;
    endfunction

    function automatic mosaic_setting_t small_setting();
        mosaic_setting_t s;
        s.image_width = $urandom_range(1, 24);
        s.region_x    = $urandom_range(0, s.image_width + 1);
        s.region_y    = $urandom_range(0, 6);
        s.region_w    = $urandom_range(0, 32);
        s.region_h    = $urandom_range(0, 16);
        s.block_count = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
        return s;
    endfunction

    function automatic mosaic_setting_t wild_setting();
        mosaic_setting_t s;
        s = small_setting();
        case ($urandom_range(0, 3))
            0: s.image_width = 1;
            1: s.image_width = 1024;
            2: s.image_width = 0;
            default: ;
        endcase
        case ($urandom_range(0, 2))
            0: s.region_x = 0;
            1: s.region_x = 1023;
            default: ;
        endcase
        case ($urandom_range(0, 2))
            0: s.region_y = 0;
            1: s.region_y = 1023;
            default: ;
        endcase
        case ($urandom_range(0, 2))
            0: s.region_w = 0;
            1: s.region_w = 1024;
            default: ;
        endcase
        case ($urandom_range(0, 2))
            0: s.region_h = 0;
            1: s.region_h = 1024;
            default: ;
        endcase
        case ($urandom_range(0, 3))
            0: s.block_count = 1;
            1: s.block_count = 1024;
            2: s.block_count = 0;
            default: ;
        endcase
        return s;
    endfunction

    function automatic int unsigned pick_gap();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 1;
            2: return $urandom_range(1, 4);
            default: return $urandom_range(5, 12);
        endcase
    endfunction

    function automatic int unsigned pick_burst();
        case ($urandom_range(0, 3))
            0: return $urandom_range(1, 4);
            1: return $urandom_range(1, 32);
            2: return 100;
            default: return $urandom_range(5, 16);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(value);
        @(posedge i_clk);
        model_write(idx, value);
    endtask

    task automatic write_setting(input mosaic_setting_t s);
        write_reg(CFG_IMAGE_WIDTH, s.image_width);
        write_reg(CFG_REGION_X, s.region_x);
        write_reg(CFG_REGION_Y, s.region_y);
        write_reg(CFG_REGION_W, s.region_w);
        write_reg(CFG_REGION_H, s.region_h);
        write_reg(CFG_BLOCK_COUNT, s.block_count);
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic fs);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = pick_gap();
            if (gap != 0) begin
                pix_in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = pick_burst();
        end
        pix_in_ch.valid <= 1'b1;
        pix_in_ch.data  <= '{pixel_in: pix, frame_start: fs};
        do @(posedge i_clk); while (!pix_in_ch.ready);
        expected_pixels.push_back(predict_mosaic_pixel(pix, fs));
        burst_left--;
        pixels_sent++;
    endtask

    task automatic drain_pixels();
        pix_in_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
    endtask

    // open each frame with frame_start, restart it now and then
    task automatic stream_frame(input int unsigned count);
        logic [PIXEL_W-1:0] pix;
        for (int unsigned n = 0; n < count; n++) begin
            case ($urandom_range(0, 15))
                0: pix = '0;
                1: pix = '1;
                default: pix = $urandom();
            endcase
            send_pixel(pix, (n == 0) || ($urandom_range(0, 79) == 0));
            random_pixels++;
        end
    endtask

    task automatic test_passthrough_after_reset();
        send_pixel('0, 1'b1);
        send_pixel('1, 1'b0);
        send_pixel($urandom(), 1'b0);
        drain_pixels();
    endtask

    task automatic test_clipped_blocks();
        write_setting('{4, 1, 1, 5, 4, 2});
        for (int unsigned n = 0; n < 20; n++)
            send_pixel((n == 0) ? '1 : $urandom(), n == 0);
        drain_pixels();
    endtask

    task automatic test_zero_block_count();
        write_setting('{4, 0, 0, 8, 8, 0});
        send_pixel($urandom(), 1'b1);
        send_pixel($urandom(), 1'b0);
        drain_pixels();
    endtask

    task automatic test_extreme_settings();
        mosaic_setting_t corners [5];
        corners[0] = '{1024, 0, 0, 1024, 1024, 1024};
        corners[1] = '{1, 0, 1023, 1024, 1024, 1};
        corners[2] = '{0, 1023, 0, 1024, 1024, 1};
        corners[3] = '{16, 0, 0, 1024, 1024, 1};
        corners[4] = '{3, 2, 0, 1, 4, 1};
        foreach (corners[i]) begin
            write_setting(corners[i]);
            stream_frame(40);
            drain_pixels();
        end
    endtask

    task automatic test_random_frames();
        mosaic_setting_t s;
        while (random_pixels < RANDOM_PIXELS) begin
            if ($urandom_range(0, 3) == 0) s = wild_setting();
            else s = small_setting();
            write_setting(s);
            stream_frame($urandom_range(40, 140));
            drain_pixels();
        end
    endtask

    initial begin : output_side
        rx_mode_t    rx_mode;
        int unsigned mode_left;
        int unsigned tick;
        t_pix_out    want;
        pix_out_ch.ready <= 1'b0;
        rx_mode   = RX_OPEN;
        mode_left = 0;
        tick      = 0;
        forever begin
            @(posedge i_clk);
            if (pix_out_ch.valid && pix_out_ch.ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected output transaction: pixel_out %h in_mosaic %b",
                           pix_out_ch.data.pixel_out, pix_out_ch.data.in_mosaic);
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    pixels_checked++;
                    if (want.in_mosaic) mosaic_hits++;
                    if (pix_out_ch.data.pixel_out !== want.pixel_out) begin
                        $error("pixel_out mismatch: expected %h, actual %h",
                               want.pixel_out, pix_out_ch.data.pixel_out);
                        fail_count++;
                    end
                    if (pix_out_ch.data.in_mosaic !== want.in_mosaic) begin
                        $error("in_mosaic mismatch: expected %b, actual %b",
                               want.in_mosaic, pix_out_ch.data.in_mosaic);
                        fail_count++;
                    end
                end
            end
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            tick++;
            case (rx_mode)
                RX_OPEN:  pix_out_ch.ready <= 1'b1;
                RX_LIGHT: pix_out_ch.ready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY: pix_out_ch.ready <= ($urandom_range(0, 2) == 0);
                default:  pix_out_ch.ready <= tick[2];
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("timeout with %0d results outstanding", expected_pixels.size());
            $display("region_mosaic_pixelate_unit_tb failed");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_IMAGE_WIDTH;
        i_cfg_data      <= '0;
        pix_in_ch.valid <= 1'b0;
        pix_in_ch.data  <= '0;
        reset_mosaic_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_passthrough_after_reset();
        test_clipped_blocks();
        test_zero_block_count();
        test_extreme_settings();
        test_random_frames();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("sent %0d pixels under %0d register settings, idle and stall at random",
                 pixels_sent, settings_applied);
        $display("checked %0d results, %0d of them inside mosaic blocks",
                 pixels_checked, mosaic_hits);
        if (fail_count == 0) begin
            $display("region_mosaic_pixelate_unit_tb passed");
        end else begin
            $display("region_mosaic_pixelate_unit_tb failed");
        end
        $finish;
    end

endmodule

/* files.f */
sv/rmp_pkg.sv
sv/rmp_pix_in_if.sv
sv/rmp_pix_out_if.sv
sv/rmp_div.sv
sv/region_mosaic_pixelate_unit.sv
tb/sv/region_mosaic_pixelate_unit_tb.sv
